>>> rtl/core/u16u8_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and byte encoding functions of the UTF-16 to UTF-8 transcoder.
package u16u8_pkg;

  // Surrogate ranges and the replacement character.
  localparam logic [15:0] HIGH_FIRST   = 16'hD800;
  localparam logic [15:0] HIGH_LAST    = 16'hDBFF;
  localparam logic [15:0] LOW_FIRST    = 16'hDC00;
  localparam logic [15:0] LOW_LAST     = 16'hDFFF;
  localparam logic [20:0] REPLACEMENT  = 21'h00FFFD;
  localparam logic [20:0] SUPP_BASE    = 21'h010000;

  // Encoded length minus one for each UTF-8 form.
  localparam logic [1:0] LEN_ONE   = 2'd0;
  localparam logic [1:0] LEN_TWO   = 2'd1;
  localparam logic [1:0] LEN_THREE = 2'd2;
  localparam logic [1:0] LEN_FOUR  = 2'd3;

  // Depth of the job queue between the front and the back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef struct packed {
    logic [15:0] code_unit;
    logic        string_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_done;
  } out_item_t;

  // One classified input item: an optional U+FFFD first, then an optional code point.
  typedef struct packed {
    logic        fffd_first;
    logic        has_cp;
    logic [20:0] cp;
    logic [1:0]  len_m1;
    logic        str_end;
  } job_t;

  // Number of UTF-8 bytes of a code point, minus one.
  function automatic logic [1:0] utf8_len_m1(input logic [20:0] cp);
    logic [1:0] len;
    if (cp[20:16] != 5'd0) begin
      len = LEN_FOUR;
    end else if (cp[15:11] != 5'd0) begin
      len = LEN_THREE;
    end else if (cp[10:7] != 4'd0) begin
      len = LEN_TWO;
    end else begin
      len = LEN_ONE;
    end
    return len;
  endfunction

  // Byte number idx of the UTF-8 form of a code point.
  function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] len_m1,
                                           input logic [1:0] idx);
    logic [7:0] b;
    b = 8'h00;
    unique case (len_m1)
      LEN_ONE: begin
        b = {1'b0, cp[6:0]};
      end
      LEN_TWO: begin
        b = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
      end
      LEN_THREE: begin
        unique case (idx)
          2'd0:    b = {4'b1110, cp[15:12]};
          2'd1:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      default: begin
        unique case (idx)
          2'd0:    b = {5'b11110, cp[20:18]};
          2'd1:    b = {2'b10, cp[17:12]};
          2'd2:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
    endcase
    return b;
  endfunction

endpackage

>>> rtl/core/u16u8_front.sv
`timescale 1ns / 1ps
// Front end: accepts code units, pairs surrogates and classifies each item into a job.
module u16u8_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  u16u8_pkg::in_item_t in_item,
  input  logic                q_full,
  output logic                q_wr,
  output u16u8_pkg::job_t     q_wr_job
);

  logic       high_pending_r, high_pending_nxt;
  logic [9:0] held_r, held_nxt;
  logic       accept;
  logic       is_high;
  logic       is_low;
  logic [20:0] cp;
  logic        has_cp;
  logic        fffd_first;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  // Surrogate classification of the incoming unit.
  assign is_high = (in_item.code_unit >= u16u8_pkg::HIGH_FIRST) &&
                   (in_item.code_unit <= u16u8_pkg::HIGH_LAST);
  assign is_low  = (in_item.code_unit >= u16u8_pkg::LOW_FIRST) &&
                   (in_item.code_unit <= u16u8_pkg::LOW_LAST);

  // Decide which code points this item produces and what stays held.
  always_comb begin
    fffd_first       = 1'b0;
    has_cp           = 1'b0;
    cp               = {5'd0, in_item.code_unit};
    high_pending_nxt = high_pending_r;
    held_nxt         = held_r;
    if (accept) begin
      if (high_pending_r && is_low) begin
        has_cp           = 1'b1;
        cp               = u16u8_pkg::SUPP_BASE + {1'b0, held_r, in_item.code_unit[9:0]};
        high_pending_nxt = 1'b0;
        held_nxt         = 10'd0;
      end else begin
        fffd_first       = high_pending_r;
        high_pending_nxt = 1'b0;
        held_nxt         = 10'd0;
        if (is_high) begin
          if (in_item.string_end) begin
            has_cp = 1'b1;
            cp     = u16u8_pkg::REPLACEMENT;
          end else begin
            high_pending_nxt = 1'b1;
            held_nxt         = in_item.code_unit[9:0];
          end
        end else if (is_low) begin
          has_cp = 1'b1;
          cp     = u16u8_pkg::REPLACEMENT;
        end else begin
          has_cp = 1'b1;
        end
      end
    end
  end

  // A job is queued only when the item yields at least one byte.
  assign q_wr                = accept && (fffd_first || has_cp);
  assign q_wr_job.fffd_first = fffd_first;
  assign q_wr_job.has_cp     = has_cp;
  assign q_wr_job.cp         = cp;
  assign q_wr_job.len_m1     = u16u8_pkg::utf8_len_m1(cp);
  assign q_wr_job.str_end    = in_item.string_end;

  // Held surrogate state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_pending_r <= 1'b0;
      held_r         <= 10'd0;
    end else begin
      high_pending_r <= high_pending_nxt;
      held_r         <= held_nxt;
    end
  end

  // Nothing stays held once a string has ended.
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_item.string_end) |=> !high_pending_r)
    else $error("surrogate still held after end of string");

  // Every end-of-string item queues a job.
  a_end_queues: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_item.string_end) |-> q_wr)
    else $error("end-of-string item produced no job");

endmodule

>>> rtl/core/u16u8_queue.sv
`timescale 1ns / 1ps
// Short job queue that decouples the front end from the byte sequencer.
module u16u8_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  u16u8_pkg::job_t wr_job,
  output logic            full,
  input  logic            rd_en,
  output logic            empty,
  output u16u8_pkg::job_t rd_job
);

  localparam logic [u16u8_pkg::QPTR_W:0] DEPTH_C = (u16u8_pkg::QPTR_W + 1)'(u16u8_pkg::QDEPTH);

  u16u8_pkg::job_t                slot_r [u16u8_pkg::QDEPTH];
  logic [u16u8_pkg::QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [u16u8_pkg::QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [u16u8_pkg::QPTR_W:0]     count_r, count_nxt;
  logic                           do_wr;
  logic                           do_rd;

  assign full   = (count_r == DEPTH_C);
  assign empty  = (count_r == '0);
  assign rd_job = slot_r[rd_ptr_r];
  assign do_wr  = wr_en && !full;
  assign do_rd  = rd_en && !empty;

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Job storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_job;
    end
  end

  // Occupancy never exceeds the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("job queue overfilled");

  // A lone read lowers the occupancy by one.
  a_read_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (do_rd && !do_wr) |=> (count_r == $past(count_r) - 1'b1))
    else $error("job queue occupancy wrong after read");

endmodule

>>> rtl/core/u16u8_back.sv
`timescale 1ns / 1ps
// Back end: queued jobs to UTF-8 bytes in an output register, one per cycle with room.
module u16u8_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  u16u8_pkg::job_t      q_job,
  output logic                 q_rd,
  output logic                 out_empty,
  input  logic                 out_pop,
  output u16u8_pkg::out_item_t out_item
);

  logic                 in_cp_r, in_cp_nxt;
  logic [1:0]           idx_r, idx_nxt;
  logic                 out_valid_r, out_valid_nxt;
  u16u8_pkg::out_item_t out_r, out_nxt;
  logic                 adv;
  logic                 in_cp;
  logic                 last;
  logic [7:0]           cur_byte;

  assign out_empty = !out_valid_r;
  assign out_item  = out_r;

  // A byte moves forward when a job waits and the output register is free or drains.
  assign adv   = !q_empty && (!out_valid_r || out_pop);
  assign in_cp = in_cp_r || !q_job.fffd_first;

  // Current byte and whether it closes the job.
  always_comb begin
    if (in_cp) begin
      cur_byte = u16u8_pkg::utf8_byte(q_job.cp, q_job.len_m1, idx_r);
      last     = (idx_r == q_job.len_m1);
    end else begin
      cur_byte = u16u8_pkg::utf8_byte(u16u8_pkg::REPLACEMENT, u16u8_pkg::LEN_THREE, idx_r);
      last     = (idx_r == u16u8_pkg::LEN_THREE) && !q_job.has_cp;
    end
  end

  assign q_rd = adv && last;

  // Sequencer and output register next state.
  always_comb begin
    in_cp_nxt     = in_cp_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (adv) begin
      out_valid_nxt       = 1'b1;
      out_nxt.out_byte    = cur_byte;
      out_nxt.run_last    = last;
      out_nxt.string_done = last && q_job.str_end;
      if (last) begin
        in_cp_nxt = 1'b0;
        idx_nxt   = 2'd0;
      end else if (!in_cp && (idx_r == u16u8_pkg::LEN_THREE)) begin
        in_cp_nxt = 1'b1;
        idx_nxt   = 2'd0;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_cp_r     <= 1'b0;
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      in_cp_r     <= in_cp_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  // A job leaves the queue exactly with the byte that carries run_last.
  a_pop_with_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_rd |=> (out_valid_r && out_r.run_last))
    else $error("job retired without its last byte");

  // string_done only ever comes with run_last.
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.string_done) |-> out_r.run_last)
    else $error("string_done without run_last");

endmodule

>>> rtl/core/utf16_to_utf8_transcoder.sv
`timescale 1ns / 1ps
// Top level of the UTF-16 to UTF-8 transcoder.
// Each transfer in is one UTF-16 code unit; each transfer out is one UTF-8 byte, with
// run_last on the last byte of an input item and string_done on the final byte of a
// string. The front end takes one unit per cycle unless the queue is full and puts a
// job in the four-entry queue for each unit that yields bytes; the back end, which sets
// the sustained rate, emits one byte per cycle while a job waits and the output has
// room. An item yields 0 bytes for a held high surrogate, 1 to 3 for a BMP unit, 4 for
// a surrogate pair, up to 6 when a dangling high surrogate is flushed as U+FFFD first.
// A lone surrogate, or a high surrogate at the end of a string, becomes EF BF BD.
module utf16_to_utf8_transcoder (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  u16u8_pkg::in_item_t  in_item,
  output logic                 out_empty,
  input  logic                 out_pop,
  output u16u8_pkg::out_item_t out_item
);

  logic            q_wr;
  logic            q_full;
  logic            q_rd;
  logic            q_empty;
  u16u8_pkg::job_t q_wr_job;
  u16u8_pkg::job_t q_rd_job;

  u16u8_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_item  (in_item),
    .q_full   (q_full),
    .q_wr     (q_wr),
    .q_wr_job (q_wr_job)
  );

  u16u8_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (q_wr),
    .wr_job (q_wr_job),
    .full   (q_full),
    .rd_en  (q_rd),
    .empty  (q_empty),
    .rd_job (q_rd_job)
  );

  u16u8_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_job     (q_rd_job),
    .q_rd      (q_rd),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule
